>>> src/ccc_pkg.sv
// Shared types, codes and helper functions for the coin credit counter.
// Used by every module under src; has no dependencies of its own.
package ccc_pkg;

  localparam int unsigned CreditW  = 7;
  localparam int unsigned SampleW  = 8;
  localparam int unsigned BcdW     = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 40;

  localparam logic [CreditW-1:0] CreditMax = 7'd99;
  localparam logic [7:0]         ReqEndDemo = 8'h03;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] FuncFrame = 2'd0;
  localparam logic [1:0] FuncAdd   = 2'd1;
  localparam logic [1:0] FuncSub   = 2'd2;

  // Coin modes.
  localparam logic [1:0] ModeShared = 2'd0;
  localparam logic [1:0] ModeIndiv  = 2'd1;

  // Player numbers.
  localparam logic [1:0] PlayerOne = 2'd1;
  localparam logic [1:0] PlayerTwo = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegCoinMode     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoin1Credits = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCoin2Credits = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStartForced  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegStartTime    = 3'd4;

  typedef struct packed {
    logic [1:0]         coin_mode;
    logic [CreditW-1:0] coin1_credits;
    logic [CreditW-1:0] coin2_credits;
    logic               start_forced;
    logic [7:0]         start_time;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [SampleW-1:0] coin_inputs_raw;
    logic               free_play;
    logic               game_mode;
    logic [7:0]         request_code;
    logic [1:0]         player_number;
    logic [CreditW-1:0] credit_amount;
  } item_t;

  typedef struct packed {
    logic [BcdW-1:0]    player1_credit_bcd;
    logic [BcdW-1:0]    player2_credit_bcd;
    logic [SampleW-1:0] coin_rise;
    logic               coin_seen;
    logic               timer_reload;
    logic [7:0]         timer_value;
    logic               coin_sound;
    logic               end_demo;
  } res_t;

  // Binary 0..99 to two BCD digits; the tens digit comes from v * 205 / 2048.
  function automatic logic [BcdW-1:0] bin_to_bcd(input logic [CreditW-1:0] v);
    logic [17:0]        prod;
    logic [3:0]         tens;
    logic [CreditW-1:0] ones;
    prod = 18'(v) * 18'd205;
    tens = prod[14:11];
    ones = v - 7'(7'(tens) * 7'd10);
    return {tens, ones[3:0]};
  endfunction

  // Add with saturation at the credit maximum.
  function automatic logic [CreditW-1:0] sat_add(input logic [CreditW-1:0] c,
                                                 input logic [8:0] a);
    logic [9:0] s;
    s = 10'(c) + 10'(a);
    return (s > 10'(CreditMax)) ? CreditMax : s[CreditW-1:0];
  endfunction

endpackage

>>> src/ccc_cfg_regs.sv
// Configuration register file of the coin credit counter.
// Depends on ccc_pkg for the register indexes and the cfg_t bundle.
module ccc_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ccc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ccc_pkg::CfgDataW-1:0] cfg_data_i,
  output ccc_pkg::cfg_t               cfg_o
);
  import ccc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegCoinMode:     cfg_d.coin_mode     = cfg_data_i[1:0];
        RegCoin1Credits: cfg_d.coin1_credits = cfg_data_i[CreditW-1:0];
        RegCoin2Credits: cfg_d.coin2_credits = cfg_data_i[CreditW-1:0];
        RegStartForced:  cfg_d.start_forced  = cfg_data_i[0];
        RegStartTime:    cfg_d.start_time    = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coin_mode     <= ModeShared;
      cfg_q.coin1_credits <= 7'd1;
      cfg_q.coin2_credits <= 7'd1;
      cfg_q.start_forced  <= 1'b0;
      cfg_q.start_time    <= 8'd30;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> src/ccc_credit_core.sv
// Coin edge detection and per-player credit state, updated once per item.
// Depends on ccc_pkg for types, codes and the BCD and saturation helpers.
module ccc_credit_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  ccc_pkg::item_t item_i,
  input  ccc_pkg::cfg_t  cfg_i,
  output ccc_pkg::res_t  res_o
);
  import ccc_pkg::*;

  // Credits are held in binary and shown as BCD on the way out.
  logic [CreditW-1:0] cred1_q, cred1_d, cred2_q, cred2_d;
  logic [SampleW-1:0] cur_q, cur_d, rise_q, rise_d;

  logic               is_frame, is_add, is_sub, may_credit;
  logic               c1, c2, seen, reload, sound;
  logic [SampleW-1:0] now;
  logic [8:0]         add1, add2;
  logic               sel1, sel2;

  always_comb begin
    is_frame = (item_i.func == FuncFrame);
    is_add   = (item_i.func == FuncAdd);
    is_sub   = (item_i.func == FuncSub);
    now      = ~item_i.coin_inputs_raw;

    cur_d  = cur_q;
    rise_d = rise_q;
    if (is_frame) begin
      cur_d  = now;
      rise_d = now & ~cur_q;
    end

    may_credit = is_frame && !item_i.free_play &&
                 (cfg_i.coin_mode == ModeShared || cfg_i.coin_mode == ModeIndiv);
    c1   = may_credit && rise_d[0];
    c2   = may_credit && rise_d[1];
    seen = c1 || c2;

    // In shared mode both slots land on player one; sequential saturation
    // equals one saturation of the total since all amounts are positive.
    add1 = 9'(c1 ? cfg_i.coin1_credits : 7'd0) +
           9'((c2 && cfg_i.coin_mode == ModeShared) ? cfg_i.coin2_credits : 7'd0);
    add2 = 9'((c2 && cfg_i.coin_mode == ModeIndiv) ? cfg_i.coin2_credits : 7'd0);

    sel1 = !item_i.free_play && item_i.player_number == PlayerOne;
    sel2 = !item_i.free_play && item_i.player_number == PlayerTwo;

    cred1_d = cred1_q;
    cred2_d = cred2_q;
    if (is_frame) begin
      cred1_d = sat_add(cred1_q, add1);
      cred2_d = sat_add(cred2_q, add2);
    end else if (is_add) begin
      if (sel1) cred1_d = sat_add(cred1_q, 9'(item_i.credit_amount));
      if (sel2) cred2_d = sat_add(cred2_q, 9'(item_i.credit_amount));
    end else if (is_sub) begin
      if (sel1) begin
        cred1_d = (item_i.credit_amount > cred1_q) ? '0 : cred1_q - item_i.credit_amount;
      end
      if (sel2) begin
        cred2_d = (item_i.credit_amount > cred2_q) ? '0 : cred2_q - item_i.credit_amount;
      end
    end

    reload = seen && !cfg_i.start_forced;
    sound  = seen && item_i.game_mode;

    res_o.player1_credit_bcd = bin_to_bcd(cred1_d);
    res_o.player2_credit_bcd = bin_to_bcd(cred2_d);
    res_o.coin_rise          = rise_d;
    res_o.coin_seen          = seen;
    res_o.timer_reload       = reload;
    res_o.timer_value        = reload ? cfg_i.start_time : 8'd0;
    res_o.coin_sound         = sound;
    res_o.end_demo           = sound && (item_i.request_code != ReqEndDemo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cred1_q <= '0;
      cred2_q <= '0;
      cur_q   <= '0;
      rise_q  <= '0;
    end else if (en_i) begin
      cred1_q <= cred1_d;
      cred2_q <= cred2_d;
      cur_q   <= cur_d;
      rise_q  <= rise_d;
    end
  end

  a_cred_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cred1_q <= CreditMax && cred2_q <= CreditMax)
    else $error("credit count beyond maximum");

  a_free_play_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && item_i.free_play |=> $stable(cred1_q) && $stable(cred2_q))
    else $error("credit changed during free play");

  a_rise_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && !is_frame |=> $stable(rise_q) && $stable(cur_q))
    else $error("coin samples changed on a non-frame item");

endmodule

>>> src/coin_credit_counter_core.sv
// Top level of the coin credit counter: stream ports, input and result registers.
// Depends on ccc_pkg, ccc_cfg_regs and ccc_credit_core.
//
// The block accepts one item per clock cycle unless the result register is stalled,
// and returns exactly one result per item: the item waits in the input register, then
// the credit and edge update runs in a single pass into the result register.
// The credit state is written in the same cycle as the result, so back-to-back items
// see each other's updates. A stalled result register holds its transaction while the
// input register may still take the next one. Configuration writes are always ready and
// take effect on the next cycle; they are to be made only while no item is in flight.
module coin_credit_counter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ccc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ccc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [7:0] coin_inputs_raw, [8] free_play, [9] game_mode, [17:10] request_code,
  // [19:18] player_number, [26:20] credit_amount, [31:27] zero
  input  logic [ccc_pkg::InDataW-1:0]   s_axis_tdata_i,
  // [1:0] func
  input  logic [1:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [7:0] player1_credit_bcd, [15:8] player2_credit_bcd, [23:16] coin_rise,
  // [24] coin_seen, [25] timer_reload, [33:26] timer_value, [34] coin_sound,
  // [35] end_demo, [39:36] zero
  output logic [ccc_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import ccc_pkg::*;

  cfg_t  cfg;
  item_t item_q, item_in;
  res_t  res, res_q;
  logic  in_valid_q, out_valid_q, adv, in_take;

  ccc_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  ccc_credit_core u_core (
    .clk_i,
    .rst_ni,
    .en_i   (adv),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_comb begin
    item_in.func            = s_axis_tuser_i;
    item_in.coin_inputs_raw = s_axis_tdata_i[7:0];
    item_in.free_play       = s_axis_tdata_i[8];
    item_in.game_mode       = s_axis_tdata_i[9];
    item_in.request_code    = s_axis_tdata_i[17:10];
    item_in.player_number   = s_axis_tdata_i[19:18];
    item_in.credit_amount   = s_axis_tdata_i[26:20];
  end

  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_in;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, res_q.end_demo, res_q.coin_sound, res_q.timer_value,
                            res_q.timer_reload, res_q.coin_seen, res_q.coin_rise,
                            res_q.player2_credit_bcd, res_q.player1_credit_bcd};

  a_reload_needs_coin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.timer_reload || res_q.coin_sound) |-> res_q.coin_seen)
    else $error("timer reload or coin sound without a credited coin");

  a_demo_needs_sound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.end_demo |-> res_q.coin_sound)
    else $error("end of demo requested without coin sound");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(m_axis_tdata_o))
    else $error("stalled result transaction changed or dropped");

endmodule
